FILE: design/dsn_pkg.sv
// Shared types and constants for the depth pixel normalizer.
// Used by the top level, the checker and the testbench.
package dsn_pkg;

    localparam int RAW_BITS_DEF = 11;
    localparam int OUT_BITS_DEF = 16;

    // Sensor curve constants with 28 fraction bits (K1 in Q2.28)
    localparam int K1_W = 30;
    localparam int K2_W = 20;
    localparam logic [K1_W-1:0] K1_Q28 = 30'd875218557;
    localparam logic [K2_W-1:0] K2_Q28 = 20'd804089;

    // Depth in Q.16, saturated at 2^21
    localparam int Z_W   = 22;
    localparam logic [Z_W-1:0] Z_SAT = 22'h200000;
    // Quotient of 2^44 by the denominator: 2^22 as starting remainder
    localparam logic [Z_W:0] NUM_HI = 23'h400000;

    localparam int PLANE_W = 21;
    localparam int NORM_W  = 17;
    localparam int FRAC_W  = 16;
    localparam logic [NORM_W-1:0] ONE_Q16 = 17'h10000;

    // Divider widths
    localparam int DIV1_DW = 30;
    localparam int DIV1_QB = 22;
    localparam int DIV2_DW = PLANE_W;
    localparam int DIV2_QB = FRAC_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_PLANE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_PLANE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL  = 3'd4;

    typedef enum logic [1:0] {
        CLIP_ERASE_BACK  = 2'd0,
        CLIP_ERASE_FRONT = 2'd1,
        CLIP_CLAMP_BACK  = 2'd2,
        CLIP_CLAMP_FRONT = 2'd3
    } clip_mode_t;

    // How the normalized value is formed
    typedef enum logic [1:0] {
        NK_DIV  = 2'd0,
        NK_ZERO = 2'd1,
        NK_ONE  = 2'd2
    } norm_kind_t;

endpackage

FILE: design/dsn_div_cell.sv
// One restoring-division step: retires one quotient bit per beat while adv is high.
// Depends on nothing but its parameters.
module dsn_div_cell #(
    parameter int DW = 30,
    parameter int QB = 22,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QB-1:0] in_low,
    input  logic [QB-1:0] in_q,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [QB-1:0] out_low,
    output logic [QB-1:0] out_q,
    output logic [DW-1:0] out_div,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QB-1:0] low_reg, q_reg;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial;
    logic          take;

    always_comb begin
        trial    = {in_rem, in_low[QB-1]};
        take     = trial >= {1'b0, in_div};
        rem_next = take ? DW'(trial - {1'b0, in_div}) : trial[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg  <= rem_next;
            low_reg  <= {in_low[QB-2:0], 1'b0};
            q_reg    <= {in_q[QB-2:0], take};
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_q     = q_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

FILE: design/dsn_div_chain.sv
// Row of QB division cells; each beat moves one cell to the right.
// Depends on dsn_div_cell.
module dsn_div_chain #(
    parameter int DW = 30,
    parameter int QB = 22,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QB-1:0] in_low,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QB-1:0] out_q,
    output logic [SW-1:0] out_side
);

    logic          v_c    [0:QB];
    logic [DW-1:0] rem_c  [0:QB];
    logic [QB-1:0] low_c  [0:QB];
    logic [QB-1:0] q_c    [0:QB];
    logic [DW-1:0] div_c  [0:QB];
    logic [SW-1:0] side_c [0:QB];

    assign v_c[0]    = in_valid;
    assign rem_c[0]  = in_rem;
    assign low_c[0]  = in_low;
    assign q_c[0]    = '0;
    assign div_c[0]  = in_div;
    assign side_c[0] = in_side;

    for (genvar i = 0; i < QB; i++) begin : g_cell
        dsn_div_cell #(.DW(DW), .QB(QB), .SW(SW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_valid (v_c[i]),
            .in_rem   (rem_c[i]),
            .in_low   (low_c[i]),
            .in_q     (q_c[i]),
            .in_div   (div_c[i]),
            .in_side  (side_c[i]),
            .out_valid(v_c[i+1]),
            .out_rem  (rem_c[i+1]),
            .out_low  (low_c[i+1]),
            .out_q    (q_c[i+1]),
            .out_div  (div_c[i+1]),
            .out_side (side_c[i+1])
        );
    end

    assign out_valid = v_c[QB];
    assign out_q     = q_c[QB];
    assign out_side  = side_c[QB];

endmodule

FILE: design/depth_sensor_raw_to_normalized.sv
// Top level of the depth pixel normalizer: front end, two divider chains, clip, scale.
// Depends on dsn_pkg and dsn_div_chain.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_tvalid/s_tready | s_tdata[15:0] raw_depth
//  m_      | out       | m_tvalid/m_tready | m_tdata[OUT_BITS-1:0] depth_out
//  cfg_    | in        | cfg_wr_en         | cfg_index, cfg_data
//
// One pixel per cycle sustained unless m_tready stalls; two front stages, 22 cells of
// the depth divider, two setup stages, 16 normalize divider cells, clip, output.
// The whole pipe advances together when the output register is empty or taken,
// so a stall on m_tready holds every stage and drops s_tready.
// aresetn clears valid bits and sets the configuration registers to their defaults.
module depth_sensor_raw_to_normalized
    import dsn_pkg::*;
#(
    parameter int RAW_BITS = RAW_BITS_DEF,
    parameter int OUT_BITS = OUT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] raw_depth
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [((OUT_BITS+7)/8)*8-1:0]   m_tdata,   // [OUT_BITS-1:0] depth_out
    input  logic                            cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data
);

    localparam int TD_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int PW    = K2_W + RAW_BITS;
    localparam int DSW   = ((PW > K1_W) ? PW : K1_W) + 1;
    localparam int NUM_W = 2 * Z_W + 1;
    localparam logic [DIV1_DW-1:0] RAW_DEN = DIV1_DW'((1 << RAW_BITS) - 1);
    localparam logic [OUT_BITS-1:0] OMAX = '1;

    // ---------------- configuration ----------------
    logic                linear_mode_reg;
    clip_mode_t          clip_mode_reg;
    logic [PLANE_W-1:0]  near_reg, far_reg;
    logic [NORM_W-1:0]   clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            linear_mode_reg <= 1'b1;
            clip_mode_reg   <= CLIP_ERASE_BACK;
            near_reg        <= '0;
            far_reg         <= PLANE_W'(655360);
            clip_reg        <= ONE_Q16;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LINEAR_MODE: linear_mode_reg <= cfg_data[0];
                CFG_CLIP_MODE:   clip_mode_reg   <= clip_mode_t'(cfg_data[1:0]);
                CFG_NEAR_PLANE:  near_reg        <= cfg_data;
                CFG_FAR_PLANE:   far_reg         <= cfg_data;
                CFG_CLIP_LEVEL:  clip_reg        <= (cfg_data[NORM_W-1:0] > ONE_Q16) ?
                                                    ONE_Q16 : cfg_data[NORM_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage A: mask and multiply ----------------
    logic                a_valid_reg;
    logic [RAW_BITS-1:0] a_raw_reg;
    logic [PW-1:0]       a_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_raw_reg  <= s_tdata[RAW_BITS-1:0];
            a_prod_reg <= K2_Q28 * s_tdata[RAW_BITS-1:0];
        end
    end

    // ---------------- stage B: divider setup ----------------
    logic [DSW-1:0]      d_lin;
    logic [NUM_W-1:0]    raw_num;
    logic                b_valid_reg;
    logic                b_sat_reg,  b_sat_next;
    logic [DIV1_DW-1:0]  b_rem_reg,  b_rem_next;
    logic [DIV1_QB-1:0]  b_low_reg,  b_low_next;
    logic [DIV1_DW-1:0]  b_div_reg,  b_div_next;

    always_comb begin
        d_lin   = DSW'(K1_Q28) - DSW'(a_prod_reg);
        raw_num = NUM_W'({a_raw_reg, 16'h0000});
        if (linear_mode_reg) begin
            // Denominator at or below 2^22 gives a depth past saturation
            b_sat_next = d_lin[DSW-1] || (d_lin[DSW-2:0] <= (DSW-1)'(NUM_HI));
            b_rem_next = DIV1_DW'(NUM_HI);
            b_low_next = '0;
            b_div_next = d_lin[DIV1_DW-1:0];
        end else begin
            b_sat_next = 1'b0;
            b_rem_next = DIV1_DW'(raw_num[NUM_W-1:DIV1_QB]);
            b_low_next = raw_num[DIV1_QB-1:0];
            b_div_next = RAW_DEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_sat_reg <= b_sat_next;
            b_rem_reg <= b_rem_next;
            b_low_reg <= b_low_next;
            b_div_reg <= b_div_next;
        end
    end

    logic               q1_valid;
    logic [DIV1_QB-1:0] q1;
    logic               q1_sat;

    dsn_div_chain #(.DW(DIV1_DW), .QB(DIV1_QB), .SW(1)) u_depth_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (b_valid_reg),
        .in_rem   (b_rem_reg),
        .in_low   (b_low_reg),
        .in_div   (b_div_reg),
        .in_side  (b_sat_reg),
        .out_valid(q1_valid),
        .out_q    (q1),
        .out_side (q1_sat)
    );

    // ---------------- stage C: saturate depth ----------------
    logic           c_valid_reg;
    logic [Z_W-1:0] c_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= q1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_z_reg <= (q1_sat || q1 > Z_SAT) ? Z_SAT : q1;
        end
    end

    // ---------------- stage D: classify against planes ----------------
    logic               z_gt_near, z_ge_far;
    logic               d_valid_reg;
    norm_kind_t         d_kind_reg, d_kind_next;
    logic [DIV2_DW-1:0] d_rem_reg, d_div_reg;

    always_comb begin
        z_gt_near = c_z_reg > Z_W'(near_reg);
        z_ge_far  = c_z_reg >= Z_W'(far_reg);
        if (far_reg <= near_reg) begin
            d_kind_next = z_gt_near ? NK_ONE : NK_ZERO;
        end else if (!z_gt_near) begin
            d_kind_next = NK_ZERO;
        end else if (z_ge_far) begin
            d_kind_next = NK_ONE;
        end else begin
            d_kind_next = NK_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_kind_reg <= d_kind_next;
            d_rem_reg  <= c_z_reg[PLANE_W-1:0] - near_reg;
            d_div_reg  <= far_reg - near_reg;
        end
    end

    logic               q2_valid;
    logic [DIV2_QB-1:0] q2;
    logic [1:0]         q2_side;
    norm_kind_t         q2_kind;

    dsn_div_chain #(.DW(DIV2_DW), .QB(DIV2_QB), .SW(2)) u_norm_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (d_valid_reg),
        .in_rem   (d_rem_reg),
        .in_low   ('0),
        .in_div   (d_div_reg),
        .in_side  (d_kind_reg),
        .out_valid(q2_valid),
        .out_q    (q2),
        .out_side (q2_side)
    );

    assign q2_kind = norm_kind_t'(q2_side);

    // ---------------- stage E: clip ----------------
    logic [NORM_W-1:0] n_val, v_next;
    logic              e_valid_reg;
    logic [NORM_W-1:0] e_v_reg;

    always_comb begin
        case (q2_kind)
            NK_ONE:  n_val = ONE_Q16;
            NK_ZERO: n_val = '0;
            default: n_val = NORM_W'(q2);
        endcase
        case (clip_mode_reg)
            CLIP_ERASE_BACK:  v_next = (n_val <  clip_reg) ? n_val : ONE_Q16;
            CLIP_ERASE_FRONT: v_next = (n_val >= clip_reg) ? n_val : ONE_Q16;
            CLIP_CLAMP_BACK:  v_next = (n_val <  clip_reg) ? n_val : clip_reg;
            default:          v_next = (n_val >= clip_reg) ? n_val : clip_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= q2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_v_reg <= v_next;
        end
    end

    // ---------------- stage F: scale to output width ----------------
    logic [NORM_W+OUT_BITS-1:0] scaled;
    logic                       out_valid_reg;
    logic [OUT_BITS-1:0]        out_data_reg;

    assign scaled = e_v_reg * OMAX;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= scaled[OUT_BITS+FRAC_W-1:FRAC_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TD_W'(out_data_reg);

    // ---------------- assertions ----------------
    a_div1_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_sat_reg) |-> (b_rem_reg < b_div_reg))
        else $error("depth divider starts with remainder not below divisor");

    a_div2_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (d_valid_reg && d_kind_reg == NK_DIV) |-> (d_rem_reg < d_div_reg))
        else $error("normalize divider starts with remainder not below divisor");

    a_clip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_valid_reg && e_v_reg[NORM_W-1]) |-> (e_v_reg[FRAC_W-1:0] == '0))
        else $error("clipped value above one");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!adv && e_valid_reg) |=> e_valid_reg && $stable(e_v_reg))
        else $error("pipeline moved during output stall");

endmodule

FILE: tb/depth_checker.sv
// Checker for the depth pixel normalizer: watches the pixel, result and register ports,
// predicts each output word and compares it with what the block returns.
// Depends on dsn_pkg.
module depth_checker
    import dsn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic                 lin_mode;
    clip_mode_t           clip_sel;
    logic [PLANE_W-1:0]   near_q16;
    logic [PLANE_W-1:0]   far_q16;
    logic [NORM_W-1:0]    clip_q16;
    logic [15:0]          depth_queue[$];

    function automatic logic [15:0] predict_depth(input logic [15:0] word);
        longint raw;
        longint den;
        longint z;
        longint n;
        longint v;
        raw = longint'(word[10:0]);
        if (lin_mode) begin
            den = longint'(K1_Q28) - longint'(K2_Q28) * raw;
            if (den <= 0) begin
                z = longint'(Z_SAT);
            end else begin
                z = (64'd1 << 44) / den;
                if (z > longint'(Z_SAT)) z = longint'(Z_SAT);
            end
        end else begin
            z = (raw * 65536) / 2047;
        end
        if (far_q16 <= near_q16) begin
            n = (z > longint'(near_q16)) ? 65536 : 0;
        end else if (z <= longint'(near_q16)) begin
            n = 0;
        end else if (z >= longint'(far_q16)) begin
            n = 65536;
        end else begin
            n = ((z - longint'(near_q16)) * 65536) / longint'(far_q16 - near_q16);
        end
        case (clip_sel)
            CLIP_ERASE_BACK:  v = (n < longint'(clip_q16)) ? n : 65536;
            CLIP_ERASE_FRONT: v = (n >= longint'(clip_q16)) ? n : 65536;
            CLIP_CLAMP_BACK:  v = (n < longint'(clip_q16)) ? n : longint'(clip_q16);
            default:          v = (n >= longint'(clip_q16)) ? n : longint'(clip_q16);
        endcase
        return 16'((v * 65535) >> 16);
    endfunction

    initial begin
        errors = 0;
        pending = 0;
        results_seen = 0;
    end

    always @(posedge aclk) begin
        logic [15:0] want;
        if (!aresetn) begin
            lin_mode = 1'b1;
            clip_sel = CLIP_ERASE_BACK;
            near_q16 = '0;
            far_q16  = 21'd655360;
            clip_q16 = ONE_Q16;
            depth_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LINEAR_MODE: lin_mode = cfg_data[0];
                    CFG_CLIP_MODE:   clip_sel = clip_mode_t'(cfg_data[1:0]);
                    CFG_NEAR_PLANE:  near_q16 = cfg_data;
                    CFG_FAR_PLANE:   far_q16  = cfg_data;
                    CFG_CLIP_LEVEL:  clip_q16 = (cfg_data[16:0] > ONE_Q16) ?
                                                ONE_Q16 : cfg_data[16:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (depth_queue.size() == 0) begin
                    $error("depth_out: unexpected beat, actual %0d", m_tdata);
                    errors++;
                end else begin
                    want = depth_queue.pop_front();
                    if (m_tdata !== want) begin
                        $error("depth_out: expected %0d, actual %0d", want, m_tdata);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) depth_queue.push_back(predict_depth(s_tdata));
        end
        pending = depth_queue.size();
    end
endmodule

FILE: tb/testbench.sv
// Top of the depth normalizer testbench: clock, reset, pixel and register stimulus,
// and the verdict. Depends on dsn_pkg, depth_checker and the block itself.
module testbench
    import dsn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int DRAIN_CYCLES = 60;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    results_seen;

    bit no_idle;
    bit hold_req;
    int hold_len;
    int pixels_sent;
    int reg_writes;
    bit cur_linear;

    depth_sensor_raw_to_normalized dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    depth_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random backpressure, with long hold-offs on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_req = 1'b0;
            end else if (no_idle) begin
                m_tready = 1'b1;
            end else if ($urandom_range(0, 299) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge aclk);
            end else begin
                m_tready = ($urandom_range(0, 99) < 70);
            end
        end
    end

    // Called at a falling edge; leaves tvalid high for a back-to-back next beat
    task automatic send_pixel(input logic [15:0] word);
        int n;
        n = no_idle ? 0 : pick_gap();
        if (n > 0) begin
            s_tvalid = 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = word;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        reg_writes++;
        if (idx == CFG_LINEAR_MODE) cur_linear = val[0];
    endtask

    task automatic set_all(input logic lin, input clip_mode_t cm, input logic [20:0] nr,
                           input logic [20:0] fr, input logic [20:0] cl);
        wait_idle();
        write_reg(CFG_LINEAR_MODE, {20'd0, lin});
        write_reg(CFG_CLIP_MODE, {19'd0, cm});
        write_reg(CFG_NEAR_PLANE, nr);
        write_reg(CFG_FAR_PLANE, fr);
        write_reg(CFG_CLIP_LEVEL, cl);
    endtask

    function automatic logic [15:0] rand_pixel();
        logic [15:0] w;
        w = 16'($urandom);
        // keep linear mode mostly on the positive side of the curve
        if (cur_linear && $urandom_range(0, 1)) w[10:0] = 11'($urandom_range(0, 1100));
        return w;
    endfunction

    task automatic random_phase(input int count);
        logic [20:0] nr;
        logic [20:0] fr;
        logic [20:0] cl;
        int r;
        r = $urandom_range(0, 9);
        nr = (r < 2) ? 21'd0 : (r == 2) ? 21'h1FFFFF : 21'($urandom_range(0, 400000));
        r = $urandom_range(0, 9);
        if (r == 0) fr = nr;
        else if (r == 1) fr = 21'($urandom_range(0, nr));
        else if (r == 2) fr = 21'h1FFFFF;
        else fr = (nr + 21'($urandom_range(1, 700000)) > 21'h1FFFFF) ? 21'h1FFFFF :
                  nr + 21'($urandom_range(1, 700000));
        r = $urandom_range(0, 9);
        cl = (r < 2) ? 21'd0 : (r < 4) ? 21'd65536 : (r == 4) ? 21'($urandom) :
             21'($urandom_range(0, 65536));
        set_all(1'($urandom_range(0, 1)), clip_mode_t'($urandom_range(0, 3)), nr, fr, cl);
        repeat (count) send_pixel(rand_pixel());
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        hold_len = 0;
        pixels_sent = 0;
        reg_writes = 0;
        cur_linear = 1'b1;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset settings: zero crossing of the curve, masked high bits
        send_pixel(16'h0000);
        send_pixel(16'd1087);
        send_pixel(16'd1088);
        send_pixel(16'd1089);
        send_pixel(16'h07FF);
        send_pixel(16'hF800);
        send_pixel(16'hFFFF);
        // Raw fraction mode over a one-unit span
        set_all(1'b0, CLIP_ERASE_BACK, 21'd0, 21'd65536, 21'd65536);
        send_pixel(16'd0);
        send_pixel(16'd1024);
        send_pixel(16'h07FF);
        // Far equal to near, then far below near
        set_all(1'b0, CLIP_CLAMP_BACK, 21'd32768, 21'd32768, 21'd65536);
        send_pixel(16'd1023);
        send_pixel(16'd1024);
        set_all(1'b0, CLIP_ERASE_BACK, 21'd40000, 21'd100, 21'd65536);
        send_pixel(16'd500);
        send_pixel(16'd1500);
        // Erase-front and both clamp modes against a mid clip level
        set_all(1'b0, CLIP_ERASE_FRONT, 21'd0, 21'd65536, 21'd32768);
        send_pixel(16'd300);
        send_pixel(16'd1800);
        set_all(1'b0, CLIP_CLAMP_BACK, 21'd0, 21'd65536, 21'd32768);
        send_pixel(16'd300);
        send_pixel(16'd1800);
        set_all(1'b0, CLIP_CLAMP_FRONT, 21'd0, 21'd65536, 21'd32768);
        send_pixel(16'd300);
        send_pixel(16'd1800);
        // Clip level above one saturates; a write to an unused index does nothing
        set_all(1'b1, CLIP_CLAMP_FRONT, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF);
        write_reg(CFG_UNUSED_IDX, 21'h1FFFFF);
        send_pixel(16'd1200);
        send_pixel(16'd0);

        // Long receiver hold-off while pixels keep coming
        wait_idle();
        no_idle = 1'b1;
        hold_len = 300;
        hold_req = 1'b1;
        repeat (70) send_pixel(rand_pixel());
        no_idle = 1'b0;

        for (int p = 0; p < 7; p++) begin
            no_idle = (p == 3);
            random_phase(50);
        end
        no_idle = 1'b0;

        wait_idle();
        $display("Covered %0d pixels, %0d results, %0d register writes across both modes,",
                 pixels_sent, results_seen, reg_writes);
        $display("all clip modes, degenerate planes and a long output stall.");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
